@@ rtl/core/rffec_pkg.sv @@
package rffec_pkg;

   // Fixed sizes of the filter and its fields
   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HALF       = 2;
   localparam int PIXEL_BITS     = 16;
   localparam int WIN_DEPTH      = 2 * MAX_HALF + 1;
   localparam int WIN_IDX_BITS   = $clog2(WIN_DEPTH);
   localparam int NUM_COEF       = 5;
   localparam int COL_BITS       = 13;
   localparam int HALF_BITS      = 2;
   localparam int TAP_IDX_BITS   = HALF_BITS + 1;
   localparam int COEF_BITS      = 16;
   localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS;
   localparam int SUM_BITS       = 34;
   localparam int MAX_RESULTS    = MAX_HALF + 1;
   localparam int CNT_BITS       = $clog2(MAX_RESULTS + 1);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [COL_BITS-1:0]          col_type;
   typedef logic [HALF_BITS-1:0]         half_type;

   // Register indexes of the control port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_WIDTH = 3'd0,
      CSR_TAP_HALF  = 3'd1,
      CSR_COEF_0    = 3'd2,
      CSR_COEF_1    = 3'd3,
      CSR_COEF_2    = 3'd4,
      CSR_COEF_3    = 3'd5,
      CSR_COEF_4    = 3'd6
   } csr_index_type;

   localparam col_type  ROW_WIDTH_RESET = col_type'(800);
   localparam half_type TAP_HALF_RESET  = half_type'(1);
   localparam coef_type [NUM_COEF-1:0] COEF_RESET = {
      16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd1
   };

   // Effective row geometry after range limiting
   typedef struct packed {
      col_type  width;
      half_type half;
   } geom_type;

   // Per-result control travelling alongside the datapath
   typedef struct packed {
      logic valid;
      logic row_end;
      logic run_last;
   } tag_type;

   typedef struct packed {
      pixel_type pixel_in;
   } req_payload_type;

   typedef struct packed {
      sum_type filtered_value;
      logic    row_end;
      logic    run_last;
   } rsp_payload_type;

endpackage

@@ rtl/core/rffec_stream_if.sv @@
interface rffec_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/rffec_csr.sv @@
module rffec_csr
   import rffec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output geom_type                  geom,
   output coef_type [NUM_COEF-1:0]   coef
);

   col_type                 row_width_ff, row_width_in;
   half_type                tap_half_ff, tap_half_in;
   coef_type [NUM_COEF-1:0] coef_ff, coef_in;

   // Decode register writes
   always_comb begin
      row_width_in = row_width_ff;
      tap_half_in  = tap_half_ff;
      coef_in      = coef_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_WIDTH: row_width_in = csr_wdata[COL_BITS-1:0];
            CSR_TAP_HALF:  tap_half_in  = csr_wdata[HALF_BITS-1:0];
            CSR_COEF_0:    coef_in[0]   = coef_type'(csr_wdata);
            CSR_COEF_1:    coef_in[1]   = coef_type'(csr_wdata);
            CSR_COEF_2:    coef_in[2]   = coef_type'(csr_wdata);
            CSR_COEF_3:    coef_in[3]   = coef_type'(csr_wdata);
            CSR_COEF_4:    coef_in[4]   = coef_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         tap_half_ff  <= TAP_HALF_RESET;
         coef_ff      <= COEF_RESET;
      end else begin
         row_width_ff <= row_width_in;
         tap_half_ff  <= tap_half_in;
         coef_ff      <= coef_in;
      end
   end

   // Limit width to 1..MAX_WIDTH and half length to MAX_HALF
   always_comb begin
      if (row_width_ff == '0) begin
         geom.width = col_type'(1);
      end else if (row_width_ff > col_type'(MAX_WIDTH)) begin
         geom.width = col_type'(MAX_WIDTH);
      end else begin
         geom.width = row_width_ff;
      end
      geom.half = (tap_half_ff > half_type'(MAX_HALF)) ? half_type'(MAX_HALF) : tap_half_ff;
   end

   assign coef = coef_ff;

endmodule

@@ rtl/core/rffec_issue.sv @@
module rffec_issue
   import rffec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  geom_type                  geom,
   input  logic                      advance,
   rffec_stream_if.sink              req_if,
   output pixel_type [NUM_COEF-1:0]  opnd,
   output tag_type                   opnd_tag
);

   pixel_type [WIN_DEPTH-1:0] win_ff, win_in;
   col_type                   col_ff, col_in;
   col_type                   nxt_ff, nxt_in;
   col_type                   x_ff, x_in;
   col_type                   c_ff, c_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   pixel_type [NUM_COEF-1:0]  opnd_ff, opnd_in;
   tag_type                   tag_ff, tag_in;

   logic                      accept;
   logic                      emit;
   logic                      wrap;
   col_type                   c_new;
   col_type                   nxt_new;
   col_type                   half_col;
   col_type                   width_m1;
   logic                      last;
   logic                      reach;
   col_type                   limit;
   col_type                   span;
   logic [CNT_BITS-1:0]       n_new;

   logic [COL_BITS:0]         lane_pos [NUM_COEF];
   logic [COL_BITS:0]         lane_col [NUM_COEF];
   col_type                   lane_back [NUM_COEF];
   logic [WIN_IDX_BITS-1:0]   lane_sel [NUM_COEF];
   logic                      lane_used [NUM_COEF];

   // Take a pixel once the pending results will be gone after this cycle
   assign req_if.ready = advance && (cnt_ff <= CNT_BITS'(1));
   assign accept       = req_if.valid && req_if.ready;
   assign emit         = advance && (cnt_ff != '0);

   assign half_col = col_type'(geom.half);
   assign width_m1 = geom.width - col_type'(1);

   // Row position of the arriving pixel and how many results it releases
   always_comb begin
      wrap    = (col_ff >= geom.width);
      c_new   = wrap ? '0 : col_ff;
      nxt_new = wrap ? '0 : nxt_ff;
      last    = (c_new == width_m1);
      reach   = (c_new >= half_col);
      if (last) begin
         limit = c_new;
      end else if (reach) begin
         limit = c_new - half_col;
      end else begin
         limit = '0;
      end
      span  = limit - nxt_new + col_type'(1);
      n_new = '0;
      if ((last || reach) && (nxt_new <= limit)) begin
         n_new = (span >= col_type'(MAX_RESULTS)) ? CNT_BITS'(MAX_RESULTS) : span[CNT_BITS-1:0];
      end
   end

   // Advance the row counters and the pending result queue
   always_comb begin
      col_in = col_ff;
      nxt_in = nxt_ff;
      win_in = win_ff;
      c_in   = c_ff;
      x_in   = x_ff;
      cnt_in = cnt_ff;
      if (emit) begin
         x_in   = x_ff + col_type'(1);
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
      if (accept) begin
         win_in = {win_ff[WIN_DEPTH-2:0], req_if.payload.pixel_in};
         c_in   = c_new;
         x_in   = nxt_new;
         cnt_in = n_new;
         if (last) begin
            col_in = '0;
            nxt_in = '0;
         end else begin
            col_in = c_new + col_type'(1);
            nxt_in = nxt_new + col_type'(n_new);
         end
      end
   end

   // Pick each tap's pixel with the column clamped to the row and to the newest pixel
   always_comb begin
      for (int k = 0; k < NUM_COEF; k++) begin
         lane_pos[k] = {1'b0, x_ff} + (COL_BITS+1)'(k);
         lane_col[k] = (lane_pos[k] < {1'b0, half_col}) ? '0 : lane_pos[k] - {1'b0, half_col};
         if (lane_col[k] > {1'b0, width_m1}) begin
            lane_col[k] = {1'b0, width_m1};
         end
         if (lane_col[k] > {1'b0, c_ff}) begin
            lane_col[k] = {1'b0, c_ff};
         end
         lane_back[k] = c_ff - lane_col[k][COL_BITS-1:0];
         lane_sel[k]  = (lane_back[k] > col_type'(WIN_DEPTH - 1)) ?
                        WIN_IDX_BITS'(WIN_DEPTH - 1) : lane_back[k][WIN_IDX_BITS-1:0];
         lane_used[k] = (TAP_IDX_BITS'(k) <= {geom.half, 1'b0});
      end
   end

   // Load the operand register
   always_comb begin
      opnd_in = opnd_ff;
      tag_in  = tag_ff;
      if (advance) begin
         for (int k = 0; k < NUM_COEF; k++) begin
            opnd_in[k] = lane_used[k] ? win_ff[lane_sel[k]] : '0;
         end
         tag_in.valid    = emit;
         tag_in.row_end  = (x_ff == width_m1);
         tag_in.run_last = (cnt_ff == CNT_BITS'(1));
      end
   end

   // Register state; only col_ff, nxt_ff, cnt_ff and the valid bit take reset
   always_ff @(posedge clock) begin
      win_ff          <= win_in;
      c_ff            <= c_in;
      x_ff            <= x_in;
      opnd_ff         <= opnd_in;
      tag_ff.row_end  <= tag_in.row_end;
      tag_ff.run_last <= tag_in.run_last;
      if (reset) begin
         col_ff       <= '0;
         nxt_ff       <= '0;
         cnt_ff       <= '0;
         tag_ff.valid <= 1'b0;
      end else begin
         col_ff       <= col_in;
         nxt_ff       <= nxt_in;
         cnt_ff       <= cnt_in;
         tag_ff.valid <= tag_in.valid;
      end
   end

   assign opnd     = opnd_ff;
   assign opnd_tag = tag_ff;

endmodule

@@ rtl/core/rffec_mac.sv @@
module rffec_mac
   import rffec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  pixel_type [NUM_COEF-1:0]  opnd,
   input  tag_type                   opnd_tag,
   input  coef_type [NUM_COEF-1:0]   coef,
   output logic                      advance,
   rffec_stream_if.source            rsp_if
);

   prod_type [NUM_COEF-1:0] prod_ff, prod_in;
   tag_type                 prod_tag_ff, prod_tag_in;
   sum_type                 sum_ff, sum_in;
   tag_type                 out_tag_ff, out_tag_in;

   // Move the whole pipe whenever the result register is free or being taken
   assign advance = !out_tag_ff.valid || rsp_if.ready;

   // One multiplier per tap
   always_comb begin
      prod_in     = prod_ff;
      prod_tag_in = prod_tag_ff;
      if (advance) begin
         for (int k = 0; k < NUM_COEF; k++) begin
            prod_in[k] = prod_type'(opnd[k]) * prod_type'(coef[k]);
         end
         prod_tag_in = opnd_tag;
      end
   end

   // Sum the products into the result register
   always_comb begin
      sum_in     = sum_ff;
      out_tag_in = out_tag_ff;
      if (advance) begin
         sum_in = '0;
         for (int k = 0; k < NUM_COEF; k++) begin
            sum_in = sum_in + sum_type'(prod_ff[k]);
         end
         out_tag_in = prod_tag_ff;
      end
   end

   // Register the pipe; only the valid bits take reset
   always_ff @(posedge clock) begin
      prod_ff              <= prod_in;
      prod_tag_ff.row_end  <= prod_tag_in.row_end;
      prod_tag_ff.run_last <= prod_tag_in.run_last;
      sum_ff               <= sum_in;
      out_tag_ff.row_end   <= out_tag_in.row_end;
      out_tag_ff.run_last  <= out_tag_in.run_last;
      if (reset) begin
         prod_tag_ff.valid <= 1'b0;
         out_tag_ff.valid  <= 1'b0;
      end else begin
         prod_tag_ff.valid <= prod_tag_in.valid;
         out_tag_ff.valid  <= out_tag_in.valid;
      end
   end

   assign rsp_if.valid                  = out_tag_ff.valid;
   assign rsp_if.payload.filtered_value = sum_ff;
   assign rsp_if.payload.row_end        = out_tag_ff.row_end;
   assign rsp_if.payload.run_last       = out_tag_ff.run_last;

endmodule

@@ rtl/core/row_fir_filter_edge_clamp.sv @@
// Channel   Direction  Payload                                   Handshake
// req_if    in         pixel_in (16 s)                           valid / ready
// rsp_if    out        filtered_value (34 s), row_end, run_last  valid / ready
// csr_*     in         csr_index (3), csr_wdata (16)             csr_write_en
//
// One pixel per cycle while req_if.ready is high. A result passes the operand,
// product and result registers. A row's last pixel may release up to three
// results, sent one per cycle unless rsp_if stalls; req_if.ready is low meanwhile.
// Reset clears row position, pending results and valids; registers take defaults.
// A stalled rsp_if freezes the whole pipe and drops req_if.ready.
module row_fir_filter_edge_clamp
   import rffec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   rffec_stream_if.sink              req_if,
   rffec_stream_if.source            rsp_if,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   geom_type                geom;
   coef_type [NUM_COEF-1:0] coef;
   logic                    advance;
   pixel_type [NUM_COEF-1:0] opnd;
   tag_type                 opnd_tag;

   // Control registers
   rffec_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .geom         (geom),
      .coef         (coef)
   );

   // Pixel window, row counters and tap selection
   rffec_issue u_issue (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .advance  (advance),
      .req_if   (req_if),
      .opnd     (opnd),
      .opnd_tag (opnd_tag)
   );

   // Multiply, sum and result register
   rffec_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .opnd     (opnd),
      .opnd_tag (opnd_tag),
      .coef     (coef),
      .advance  (advance),
      .rsp_if   (rsp_if)
   );

endmodule

@@ rtl/core/rffec_checker.sv @@
module rffec_checker
   import rffec_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // Hold a refused result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or dropped while stalled");

   // Refuse pixels while the result register is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("pixel taken while output stalled");

   // The last column of a row always closes its transaction's results
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.row_end |-> rsp_payload.run_last)
      else $error("row end result not marked last");

   // Drop all results on reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Keep the result valid known after each pixel transaction
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$isunknown(rsp_valid))
      else $error("output valid unknown after a transaction");

endmodule

bind row_fir_filter_edge_clamp rffec_checker u_rffec_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
